// File: design/cscan_pkg.sv
// ----------------------------------------------------------------------------
// cscan_pkg: shared types and codes for the circle scan rasterizer
// Holds the result status codes, the command codes and the structs passed
// between the start check, the pixel test and the top level.
// ----------------------------------------------------------------------------
package cscan_pkg;

   // Command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Result status codes
   localparam logic [2:0] ST_STARTED   = 3'd0;
   localparam logic [2:0] ST_PAINT     = 3'd1;
   localparam logic [2:0] ST_SKIP      = 3'd2;
   localparam logic [2:0] ST_OFFSCREEN = 3'd3;
   localparam logic [2:0] ST_NEGATIVE  = 3'd4;
   localparam logic [2:0] ST_BADCOLOUR = 3'd5;
   localparam logic [2:0] ST_IDLE      = 3'd6;

   // Largest legal palette index
   localparam logic [8:0] COLOUR_MAX = 9'd255;

   // Verdict of the start check
   typedef struct packed {
      logic       ok;
      logic [2:0] status;
   } start_verdict_type;

   // Verdict of the pixel test for the current scan position
   typedef struct packed {
      logic paint;
      logic last;
      logic row_end;
   } pixel_verdict_type;

endpackage

// File: design/cscan_start_check.sv
// ----------------------------------------------------------------------------
// cscan_start_check: validate a start command
// Checks the circle against the screen edge, sign, colour range and
// capacity, in that priority order.
// ----------------------------------------------------------------------------
module cscan_start_check #(
   parameter int RADIUS_MAX = 255,
   parameter int COORD_MAX  = 1023
) (
   input  logic signed [8:0]             radius,
   input  logic signed [10:0]            center_row,
   input  logic signed [10:0]            center_col,
   input  logic        [8:0]             colour,
   output cscan_pkg::start_verdict_type  verdict
);
   import cscan_pkg::*;

   logic signed [12:0] row_gap;
   logic signed [12:0] col_gap;
   logic               off_edge;
   logic               negative;
   logic               bad_colour;
   logic               too_big;

   // Distance from the top and left screen edges
   assign row_gap = 13'(center_row) - 13'(radius);
   assign col_gap = 13'(center_col) - 13'(radius);

   assign off_edge   = (row_gap < 13'sd1) || (col_gap < 13'sd1);
   assign negative   = center_row[10] || center_col[10] || radius[8];
   assign bad_colour = colour > COLOUR_MAX;
   assign too_big    = (32'(radius) > RADIUS_MAX) || (32'(center_row) > COORD_MAX)
                       || (32'(center_col) > COORD_MAX);

   // Pick the first failing check
   always_comb begin
      verdict.ok = 1'b0;
      if (off_edge) begin
         verdict.status = ST_OFFSCREEN;
      end else if (negative) begin
         verdict.status = ST_NEGATIVE;
      end else if (bad_colour) begin
         verdict.status = ST_BADCOLOUR;
      end else if (too_big) begin
         verdict.status = ST_OFFSCREEN;
      end else begin
         verdict.status = ST_STARTED;
         verdict.ok     = 1'b1;
      end
   end

endmodule

// File: design/cscan_pixel_test.sv
// ----------------------------------------------------------------------------
// cscan_pixel_test: distance test for one scan position
// Squares the two offsets, compares the sum against the radius square
// (disc or ring band) and flags the row end and the final position.
// ----------------------------------------------------------------------------
module cscan_pixel_test (
   input  logic        [7:0]          radius,
   input  logic                       fill,
   input  logic signed [8:0]          row_offset,
   input  logic signed [8:0]          col_offset,
   output cscan_pkg::pixel_verdict_type verdict
);
   import cscan_pkg::*;

   logic        [7:0]  row_mag;
   logic        [7:0]  col_mag;
   logic        [15:0] row_sq;
   logic        [15:0] col_sq;
   logic        [16:0] sum_sq;
   logic        [15:0] rad_sq;
   logic        [15:0] band_lo;
   logic        [16:0] band_hi;
   logic signed [8:0]  rad_s;

   // Magnitudes, offsets never reach -256
   assign row_mag = row_offset[8] ? 8'(-row_offset) : row_offset[7:0];
   assign col_mag = col_offset[8] ? 8'(-col_offset) : col_offset[7:0];

   assign row_sq  = row_mag * row_mag;
   assign col_sq  = col_mag * col_mag;
   assign sum_sq  = 17'(row_sq) + 17'(col_sq);
   assign rad_sq  = radius * radius;
   assign band_lo = rad_sq - 16'(radius);
   assign band_hi = 17'(rad_sq) + 17'(radius);

   // Paint inside the disc, or within the ring band
   always_comb begin
      if (fill) begin
         verdict.paint = sum_sq <= 17'(rad_sq);
      end else begin
         verdict.paint = (sum_sq >= 17'(band_lo)) && (sum_sq <= band_hi);
      end
   end

   // Scan position flags
   assign rad_s           = signed'({1'b0, radius});
   assign verdict.row_end = col_offset >= rad_s;
   assign verdict.last    = verdict.row_end && (row_offset >= rad_s);

endmodule

// File: design/circle_scan_rasterizer.sv
// ----------------------------------------------------------------------------
// circle_scan_rasterizer: raster scan of a disc or ring, one position a beat
// A start beat validates and latches a circle; each step beat tests the
// next offset of the square scan and reports paint or skip.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | command, radius, centre, colour, fill
//   rsp     | out       | rsp_valid/rsp_stall | status, pixel row/col, colour, last
//
// Every beat is answered by one result in the cycle after it is taken; while req_stall
// is low, a new beat is taken every cycle. The result register is the only buffer: when
// it holds a beat and rsp_stall is high, req_stall rises in the same cycle.
// Reset (synchronous) clears the scan state and empties the result register.
// ----------------------------------------------------------------------------
module circle_scan_rasterizer #(
   parameter int RADIUS_MAX = 255,
   parameter int COORD_MAX  = 1023
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic signed [8:0]  req_radius,
   input  logic signed [10:0] req_center_row,
   input  logic signed [10:0] req_center_col,
   input  logic        [8:0]  req_colour,
   input  logic               req_fill_mode,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [2:0]  rsp_status,
   output logic        [10:0] rsp_pixel_row,
   output logic        [10:0] rsp_pixel_col,
   output logic        [7:0]  rsp_pixel_colour,
   output logic               rsp_last
);
   import cscan_pkg::*;

   // Scan state
   logic               busy_ff,       busy_in;
   logic        [7:0]  radius_ff,     radius_in;
   logic        [9:0]  row_ff,        row_in;
   logic        [9:0]  col_ff,        col_in;
   logic        [7:0]  colour_ff,     colour_in;
   logic               fill_ff,       fill_in;
   logic signed [8:0]  row_offset_ff, row_offset_in;
   logic signed [8:0]  col_offset_ff, col_offset_in;

   // Result register
   logic               rsp_valid_ff,  rsp_valid_in;
   logic        [2:0]  status_ff,     status_in;
   logic        [10:0] pix_row_ff,    pix_row_in;
   logic        [10:0] pix_col_ff,    pix_col_in;
   logic        [7:0]  pix_colour_ff, pix_colour_in;
   logic               last_ff,       last_in;

   logic               accept;
   start_verdict_type  start_v;
   pixel_verdict_type  pixel_v;
   logic signed [8:0]  neg_radius;

   cscan_start_check #(
      .RADIUS_MAX (RADIUS_MAX),
      .COORD_MAX  (COORD_MAX)
   ) u_start_check (
      .radius     (req_radius),
      .center_row (req_center_row),
      .center_col (req_center_col),
      .colour     (req_colour),
      .verdict    (start_v)
   );

   cscan_pixel_test u_pixel_test (
      .radius     (radius_ff),
      .fill       (fill_ff),
      .row_offset (row_offset_ff),
      .col_offset (col_offset_ff),
      .verdict    (pixel_v)
   );

   // Hold the input while the result register is full and stalled
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign neg_radius = -req_radius;

   // Work out the next scan state and the result of the accepted beat
   always_comb begin
      busy_in       = busy_ff;
      radius_in     = radius_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      colour_in     = colour_ff;
      fill_in       = fill_ff;
      row_offset_in = row_offset_ff;
      col_offset_in = col_offset_ff;
      status_in     = status_ff;
      pix_row_in    = pix_row_ff;
      pix_col_in    = pix_col_ff;
      pix_colour_in = pix_colour_ff;
      last_in       = last_ff;
      if (accept) begin
         status_in     = ST_IDLE;
         pix_row_in    = '0;
         pix_col_in    = '0;
         pix_colour_in = '0;
         last_in       = 1'b0;
         if (req_command == CMD_START) begin
            status_in = start_v.status;
            if (start_v.ok) begin
               busy_in       = 1'b1;
               radius_in     = req_radius[7:0];
               row_in        = req_center_row[9:0];
               col_in        = req_center_col[9:0];
               colour_in     = req_colour[7:0];
               fill_in       = req_fill_mode;
               row_offset_in = neg_radius;
               col_offset_in = neg_radius;
            end
         end else if (busy_ff) begin
            status_in     = pixel_v.paint ? ST_PAINT : ST_SKIP;
            pix_row_in    = 11'({1'b0, row_ff}) + 11'(row_offset_ff);
            pix_col_in    = 11'({1'b0, col_ff}) + 11'(col_offset_ff);
            pix_colour_in = colour_ff;
            last_in       = pixel_v.last;
            // Advance the scan, column fastest
            if (pixel_v.last) begin
               busy_in = 1'b0;
            end else if (pixel_v.row_end) begin
               col_offset_in = -signed'({1'b0, radius_ff});
               row_offset_in = row_offset_ff + 9'sd1;
            end else begin
               col_offset_in = col_offset_ff + 9'sd1;
            end
         end
      end
   end

   // Fill on accept, drop when taken
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         radius_ff     <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         colour_ff     <= '0;
         fill_ff       <= 1'b0;
         row_offset_ff <= '0;
         col_offset_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         radius_ff     <= radius_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         colour_ff     <= colour_in;
         fill_ff       <= fill_in;
         row_offset_ff <= row_offset_in;
         col_offset_ff <= col_offset_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      pix_row_ff    <= pix_row_in;
      pix_col_ff    <= pix_col_in;
      pix_colour_ff <= pix_colour_in;
      last_ff       <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_pixel_row    = pix_row_ff;
   assign rsp_pixel_col    = pix_col_ff;
   assign rsp_pixel_colour = pix_colour_ff;
   assign rsp_last         = last_ff;

   // Final scan position ends the scan
   a_last_clears_busy : assert property (@(posedge clock) disable iff (reset)
      accept && req_command == CMD_STEP && busy_ff && pixel_v.last |=> !busy_ff)
      else $error("scan still busy after final position");

   // Accepted start arms the scan at the top left corner
   a_start_arms : assert property (@(posedge clock) disable iff (reset)
      accept && req_command == CMD_START && start_v.ok
      |=> busy_ff && row_offset_ff == col_offset_ff && status_ff == ST_STARTED)
      else $error("start did not arm the scan");

   // Non-pixel results carry zero fields
   a_idle_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_PAINT && status_ff != ST_SKIP
      |-> pix_row_ff == '0 && pix_col_ff == '0 && pix_colour_ff == '0 && !last_ff)
      else $error("non-pixel result with nonzero fields");

endmodule

// File: bench/circle_scan_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// circle_scan_rasterizer_tb: self-checking bench for the circle scan rasterizer
// A queue of start and step beats is built up front: a directed opening, then
// random circles scanned through (sometimes cut short or interrupted) mixed
// with malformed starts and stray steps. A shadow of the scan state predicts
// every result, and the monitor checks the results field by field, in order.
// ----------------------------------------------------------------------------
module circle_scan_rasterizer_tb;
   import cscan_pkg::*;

   localparam int RADIUS_LIMIT  = 255;
   localparam int COORD_LIMIT   = 1023;
   localparam int RANDOM_ITEMS  = 1050;
   localparam int QUIET_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CALM_TAIL     = 150;

   typedef struct {
      logic               command;
      logic signed [8:0]  radius;
      logic signed [10:0] center_row;
      logic signed [10:0] center_col;
      logic        [8:0]  colour;
      logic               fill_mode;
   } circle_cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [10:0] pixel_row;
      logic [10:0] pixel_col;
      logic [7:0]  pixel_colour;
      logic        last;
   } scan_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic               req_command    = CMD_STEP;
   logic signed [8:0]  req_radius     = '0;
   logic signed [10:0] req_center_row = '0;
   logic signed [10:0] req_center_col = '0;
   logic        [8:0]  req_colour     = '0;
   logic               req_fill_mode  = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic        [2:0]  rsp_status;
   logic        [10:0] rsp_pixel_row;
   logic        [10:0] rsp_pixel_col;
   logic        [7:0]  rsp_pixel_colour;
   logic               rsp_last;

   circle_scan_rasterizer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_radius       (req_radius),
      .req_center_row   (req_center_row),
      .req_center_col   (req_center_col),
      .req_colour       (req_colour),
      .req_fill_mode    (req_fill_mode),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_pixel_col    (rsp_pixel_col),
      .rsp_pixel_colour (rsp_pixel_colour),
      .rsp_last         (rsp_last)
   );

   // Shadow of the scan state
   logic              scan_busy   = 1'b0;
   logic [7:0]        scan_radius = '0;
   logic [9:0]        scan_row    = '0;
   logic [9:0]        scan_col    = '0;
   logic [7:0]        scan_colour = '0;
   logic              scan_fill   = 1'b0;
   logic signed [8:0] row_step    = '0;
   logic signed [8:0] col_step    = '0;

   circle_cmd_type  pending_cmds[$];
   scan_result_type due_results[$];
   circle_cmd_type  next_cmd;
   circle_cmd_type  seen_cmd;

   int total_items    = 0;
   int sent_count     = 0;
   int accepted_count = 0;
   int fail_count     = 0;
   int quiet_cycles   = 0;
   int send_gap       = 0;
   int hold_gap       = 0;
   logic idling_on;

   // Clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Allow idling in two of every three stretches of 128 beats, never at the tail
   assign idling_on = (sent_count + CALM_TAIL < total_items) && ((sent_count / 128) % 3 != 2);

   // Advance the shadow state by one accepted beat and return its result
   function automatic scan_result_type rasterize_beat(circle_cmd_type c);
      scan_result_type res;
      int r, row, col, i, j, d, rr;
      logic paint;
      res = '0;
      if (c.command == CMD_START) begin
         r   = c.radius;
         row = c.center_row;
         col = c.center_col;
         if (row - r < 1 || col - r < 1) begin
            res.status = ST_OFFSCREEN;
         end else if (row < 0 || col < 0 || r < 0) begin
            res.status = ST_NEGATIVE;
         end else if (c.colour > COLOUR_MAX) begin
            res.status = ST_BADCOLOUR;
         end else if (r > RADIUS_LIMIT || row > COORD_LIMIT || col > COORD_LIMIT) begin
            res.status = ST_OFFSCREEN;
         end else begin
            res.status  = ST_STARTED;
            scan_busy   = 1'b1;
            scan_radius = 8'(r);
            scan_row    = 10'(row);
            scan_col    = 10'(col);
            scan_colour = 8'(c.colour);
            scan_fill   = c.fill_mode;
            row_step    = 9'(-r);
            col_step    = 9'(-r);
         end
      end else if (!scan_busy) begin
         res.status = ST_IDLE;
      end else begin
         r   = scan_radius;
         i   = row_step;
         j   = col_step;
         row = scan_row;
         col = scan_col;
         d   = i * i + j * j;
         rr  = r * r;
         paint = scan_fill ? (d <= rr) : (d >= rr - r && d <= rr + r);
         res.status       = paint ? ST_PAINT : ST_SKIP;
         res.pixel_row    = 11'(row + i);
         res.pixel_col    = 11'(col + j);
         res.pixel_colour = scan_colour;
         res.last         = (i >= r && j >= r);
         // Advance the raster position, column first
         if (res.last) begin
            scan_busy = 1'b0;
         end else if (j >= r) begin
            col_step = 9'(-r);
            row_step = 9'(i + 1);
         end else begin
            col_step = 9'(j + 1);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
      fail_count++;
   endtask

   task automatic check_result(scan_result_type got);
      scan_result_type want;
      if (due_results.size() == 0) begin
         report_mismatch("unexpected result status", got.status, -1);
      end else begin
         want = due_results.pop_front();
         if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
         if (got.pixel_row != want.pixel_row)
            report_mismatch("pixel_row", got.pixel_row, want.pixel_row);
         if (got.pixel_col != want.pixel_col)
            report_mismatch("pixel_col", got.pixel_col, want.pixel_col);
         if (got.pixel_colour != want.pixel_colour)
            report_mismatch("pixel_colour", got.pixel_colour, want.pixel_colour);
         if (got.last != want.last)
            report_mismatch("last", got.last, want.last);
      end
   endtask

   task automatic push_start(int r, int row, int col, int colour, bit fill);
      circle_cmd_type c;
      c.command    = CMD_START;
      c.radius     = 9'(r);
      c.center_row = 11'(row);
      c.center_col = 11'(col);
      c.colour     = 9'(colour);
      c.fill_mode  = fill;
      pending_cmds.push_back(c);
   endtask

   task automatic push_steps(int count);
      circle_cmd_type c;
      c.command    = CMD_STEP;
      c.radius     = 9'($urandom_range(0, 511));
      c.center_row = 11'($urandom_range(0, 2047));
      c.center_col = 11'($urandom_range(0, 2047));
      c.colour     = 9'($urandom_range(0, 511));
      c.fill_mode  = 1'($urandom_range(0, 1));
      for (int n = 0; n < count; n++)
         pending_cmds.push_back(c);
   endtask

   // Drive request beats; hold the payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 99) < 15) begin
            send_gap  <= $urandom_range(0, 10);
            req_valid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            next_cmd = pending_cmds.pop_front();
            req_command    <= next_cmd.command;
            req_radius     <= next_cmd.radius;
            req_center_row <= next_cmd.center_row;
            req_center_col <= next_cmd.center_col;
            req_colour     <= next_cmd.colour;
            req_fill_mode  <= next_cmd.fill_mode;
            req_valid      <= 1'b1;
            sent_count     <= sent_count + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result channel in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_gap  <= 0;
      end else if (hold_gap != 0) begin
         hold_gap  <= hold_gap - 1;
         rsp_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 99) < 12) begin
         hold_gap  <= $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Predict on accepted requests, check accepted results, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen_cmd.command    = req_command;
            seen_cmd.radius     = req_radius;
            seen_cmd.center_row = req_center_row;
            seen_cmd.center_col = req_center_col;
            seen_cmd.colour     = req_colour;
            seen_cmd.fill_mode  = req_fill_mode;
            due_results.push_back(rasterize_beat(seen_cmd));
            accepted_count <= accepted_count + 1;
         end
         if (rsp_valid && !rsp_stall)
            check_result({rsp_status, rsp_pixel_row, rsp_pixel_col, rsp_pixel_colour,
                          rsp_last});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Build the stimulus, release reset, wait for the drain
   initial begin
      int directed_count, pick, r, span, cut, remain;

      // Directed: idle step, zero radius in both modes, every rejection, restart
      push_steps(1);
      push_start(0, 1, 1, 0, 1'b0);
      push_steps(1);
      push_start(0, 1023, 1023, 255, 1'b1);
      push_steps(1);
      push_start(1, 1, 5, 10, 1'b1);
      push_start(1, 5, 1, 10, 1'b0);
      push_start(-10, -5, -5, 3, 1'b1);
      push_start(-256, -1, 0, 511, 1'b0);
      push_start(5, 10, 10, 256, 1'b1);
      push_start(5, 10, 10, 511, 1'b0);
      push_start(-1024, -1024, -1024, 0, 1'b0);
      push_start(255, 1023, 256, 255, 1'b1);
      push_steps(2);
      push_start(1, 2, 2, 7, 1'b0);
      push_steps(3);
      push_start(1, 2, 2, 300, 1'b1);
      push_steps(6);
      push_steps(1);
      directed_count = pending_cmds.size();

      // Random: mostly whole scans of valid circles, the rest noise
      while (pending_cmds.size() < directed_count + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 39) == 0)
               r = $urandom_range(200, 255);
            else if ($urandom_range(0, 9) == 0)
               r = $urandom_range(6, 12);
            else
               r = $urandom_range(0, 5);
            push_start(r, $urandom_range(r + 1, 1023), $urandom_range(r + 1, 1023),
                       $urandom_range(0, 255), 1'($urandom_range(0, 1)));
            span = (2 * r + 1) * (2 * r + 1);
            // Cut huge scans short; sometimes abandon a small one for a restart
            if (r > 12)
               span = $urandom_range(5, 40);
            else if ($urandom_range(0, 4) == 0)
               span = $urandom_range(1, span);
            // Keep the stimulus near its intended length
            remain = directed_count + RANDOM_ITEMS - pending_cmds.size();
            if (span > remain)
               span = (remain > 0) ? remain : 1;
            cut = ($urandom_range(0, 2) == 0) ? $urandom_range(1, span) : 0;
            push_steps(cut);
            if (cut != 0) begin
               // Drop a rejected start into the running scan
               case ($urandom_range(0, 2))
                  0: push_start(r, r + 1, r + 1, $urandom_range(256, 511), 1'b1);
                  1: push_start(r, $urandom_range(0, r), 500, 9, 1'b0);
                  default: push_start(-$urandom_range(1, 256), $urandom_range(0, 1023),
                                      $urandom_range(0, 1023), 9, 1'b1);
               endcase
            end
            push_steps(span - cut);
            if ($urandom_range(0, 3) == 0)
               push_steps(1);
         end else if (pick < 88) begin
            if ($urandom_range(0, 1) == 0)
               push_start($urandom_range(0, 511), $urandom_range(0, 2047),
                          $urandom_range(0, 2047), $urandom_range(0, 511),
                          1'($urandom_range(0, 1)));
            else
               push_start($urandom_range(0, 511), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), $urandom_range(0, 511),
                          1'($urandom_range(0, 1)));
         end else begin
            push_steps($urandom_range(1, 3));
         end
      end
      total_items = pending_cmds.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != total_items || due_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// File: filelist.f
design/cscan_pkg.sv
design/cscan_start_check.sv
design/cscan_pixel_test.sv
design/circle_scan_rasterizer.sv
bench/circle_scan_rasterizer_tb.sv
